/* rtl/core/mspd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID drive package
// Widths, fixed constants and the sequencer state type of the speed-loop PID.
// ----------------------------------------------------------------------------
package mspd_pkg;

  // Field widths.
  localparam int POS_W    = 32;
  localparam int DT_W     = 16;
  localparam int SPEED_W  = 24;
  localparam int CTRL_W   = 25;
  localparam int PWM_W    = 8;
  localparam int GAIN_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Internal arithmetic widths.
  localparam int ERR_W    = 25;             // target minus speed
  localparam int SUM_W    = ERR_W + 1;      // integral plus error before clamping
  localparam int DERIV_W  = ERR_W + 1;      // error minus previous error
  localparam int MUL_B_W  = DERIV_W;        // second operand of the shared multiplier
  localparam int PROD_W   = GAIN_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + 2;     // sum of three products
  localparam int NUM_W    = POS_W + 10;     // count difference times 1000
  localparam int MAG_W    = NUM_W - 1;
  localparam int DIV_STEPS = SPEED_W - 1;   // quotient bits below saturation
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int HI_W     = MAG_W - DIV_STEPS;

  localparam int FRAC_BITS    = 16;
  localparam int OUTPUT_LIMIT = 255;
  localparam int DUTY_MAX     = 255;
  localparam int MS_PER_S     = 1000;
  localparam longint ONE_Q16  = 64'sd65536;
  localparam longint OUT_LIM_Q16 = longint'(OUTPUT_LIMIT) * ONE_Q16;
  localparam int CLAMP_W  = $clog2(OUT_LIM_Q16 + 1) + 1;
  localparam int DUTY_W   = CLAMP_W - 1 - FRAC_BITS;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(8388607);

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PREP,
    ST_DIV,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_CLAMP,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/motor_speed_pid_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID drive
// Encoder speed measurement, PID with clamped integral and H-bridge mapping.
// ----------------------------------------------------------------------------
// Each input request carries an encoder count, the milliseconds since the
// previous sample and a target speed, and yields exactly one result request
// holding the measured speed, the clamped signed Q9.16 controller output and the
// forward and reverse PWM duties (both zero means brake). The block works on
// one sample at a time under a small sequencer and is not ready while a
// sample is in progress. From acceptance to a loaded result a sample goes
// through these steps in order: accept it, scale the count difference by
// 1000 in the shared 32 x 26 multiplier, set up the divider, the 23 steps
// of the one-bit-per-cycle restoring divider, the error and integral
// update, three passes of the shared multiplier for the P, I and D terms,
// finish the sum, clamp, and load the output register. When the elapsed
// time is zero or the speed is going to saturate, the divider is skipped.
// The output register decouples the two sides: a new sample is accepted
// while the previous result still waits to be taken, and the result is only
// held back if the one before it has still not been taken by then. The gain
// registers are written through the configuration channel, which is always
// ready; writes are expected only while no sample is in progress.
// ----------------------------------------------------------------------------
module motor_speed_pid_drive
  import mspd_pkg::*;
#(
  parameter int INTEGRAL_LIMIT = 2000
) (
  input  logic                 clk,
  input  logic                 rst,
  // Sample input. s_tdata, from bit 0 up: encoder_position[31:0],
  // elapsed_ms[47:32], target_speed[71:48].
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [71:0]          s_tdata,
  // Result output. m_tdata, from bit 0 up: measured_speed[23:0],
  // control_value[48:24], forward_pwm[56:49], reverse_pwm[64:57], zero pad.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [71:0]          m_tdata,
  // Gain register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  // The integral register is only as wide as its clamp requires.
  localparam int ESUM_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam logic signed [SUM_W-1:0] ISUM_MAX = SUM_W'(INTEGRAL_LIMIT);
  localparam logic signed [SUM_W-1:0] ISUM_MIN = -ISUM_MAX;
  localparam logic signed [ACC_W-1:0] ACC_LIM_POS = ACC_W'(OUT_LIM_Q16);
  localparam logic signed [ACC_W-1:0] ACC_LIM_NEG = -ACC_LIM_POS;
  localparam logic signed [CLAMP_W-1:0] ONE_POS = CLAMP_W'(ONE_Q16);
  localparam logic signed [CLAMP_W-1:0] ONE_NEG = -ONE_POS;

  state_t state, state_next;

  // Configuration and loop state.
  logic signed [GAIN_W-1:0]  gain_prop, gain_integ, gain_deriv;
  logic [POS_W-1:0]          last_position;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [ESUM_W-1:0]  error_sum;

  // Per-sample working registers.
  logic signed [POS_W-1:0]   delta;
  logic [DT_W-1:0]           dt;
  logic signed [SPEED_W-1:0] target;
  logic                      neg, spd_zero, spd_sat;
  logic [DT_W:0]             rem;
  logic [DIV_STEPS-1:0]      dq;
  logic [CNT_W-1:0]          cnt;
  logic signed [SPEED_W-1:0] speed;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  // Output register.
  logic                      out_valid;
  logic signed [SPEED_W-1:0] out_speed;
  logic signed [CTRL_W-1:0]  out_ctrl;
  logic [PWM_W-1:0]          out_fwd, out_rev;

  logic s_fire, out_free;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_rev, out_fwd, out_ctrl, out_speed};

  // --------------------------------------------------------------------------
  // Shared multiplier: count scaling, then the P, I and D products in turn.
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    unique case (state)
      ST_SCALE: begin
        mul_a = delta;
        mul_b = MUL_B_W'(MS_PER_S);
      end
      ST_MUL_P: begin
        mul_a = gain_prop;
        mul_b = MUL_B_W'(last_error);
      end
      ST_MUL_I: begin
        mul_a = gain_integ;
        mul_b = MUL_B_W'(error_sum);
      end
      default: begin
        mul_a = gain_deriv;
        mul_b = deriv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Divider set-up: magnitude of the scaled count and the saturation test.
  // The quotient exceeds the speed range exactly when the top bits of the
  // magnitude are not below the divisor.
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_abs;
  logic [MAG_W-1:0]        mag;
  logic [HI_W-1:0]         mag_hi;

  assign num     = prod[NUM_W-1:0];
  assign num_abs = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign mag     = num_abs[MAG_W-1:0];
  assign mag_hi  = mag[MAG_W-1:DIV_STEPS];

  // Restoring division step.
  logic [DT_W:0] trial;
  logic          trial_ge;

  assign trial    = {rem[DT_W-1:0], dq[DIV_STEPS-1]};
  assign trial_ge = (trial >= {1'b0, dt});

  // --------------------------------------------------------------------------
  // Speed, error, integral and derivative.
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] q_speed, speed_c;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [SUM_W-1:0]   sum_raw, sum_clamped;
  logic signed [DERIV_W-1:0] deriv_c;

  always_comb begin
    q_speed = $signed({1'b0, dq});
    if (spd_zero) begin
      speed_c = '0;
    end else if (spd_sat) begin
      speed_c = neg ? -SPEED_MAX : SPEED_MAX;
    end else begin
      speed_c = neg ? -q_speed : q_speed;
    end

    // A zero target clears both the error and the integral.
    if (target == '0) begin
      err_c   = '0;
      sum_raw = '0;
    end else begin
      err_c   = ERR_W'(target) - ERR_W'(speed_c);
      sum_raw = SUM_W'(error_sum) + SUM_W'(err_c);
    end

    if (sum_raw > ISUM_MAX) begin
      sum_clamped = ISUM_MAX;
    end else if (sum_raw < ISUM_MIN) begin
      sum_clamped = ISUM_MIN;
    end else begin
      sum_clamped = sum_raw;
    end

    deriv_c = DERIV_W'(err_c) - DERIV_W'(last_error);
  end

  // --------------------------------------------------------------------------
  // Output clamp and the dead-zone mapping to the bridge duties.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]   acc_sum, acc_clamped;
  logic signed [CLAMP_W-1:0] ctl;
  logic [CLAMP_W-1:0]        ctl_abs;
  logic [DUTY_W-1:0]         duty_raw;
  logic [PWM_W-1:0]          duty, fwd_c, rev_c;

  always_comb begin
    acc_sum = acc + ACC_W'(prod);

    if (acc > ACC_LIM_POS) begin
      acc_clamped = ACC_LIM_POS;
    end else if (acc < ACC_LIM_NEG) begin
      acc_clamped = ACC_LIM_NEG;
    end else begin
      acc_clamped = acc;
    end

    ctl      = acc[CLAMP_W-1:0];
    ctl_abs  = ctl[CLAMP_W-1] ? (~ctl + CLAMP_W'(1)) : ctl;
    duty_raw = ctl_abs[CLAMP_W-2:FRAC_BITS];
    duty     = (duty_raw > DUTY_W'(DUTY_MAX)) ? PWM_W'(DUTY_MAX) : PWM_W'(duty_raw);
    fwd_c    = (ctl > ONE_POS) ? duty : '0;
    rev_c    = (ctl < ONE_NEG) ? duty : '0;
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_fire) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_PREP;
      ST_PREP: begin
        if ((dt == '0) || (mag_hi >= HI_W'(dt))) begin
          state_next = ST_ERR;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:   if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_ERR;
      ST_ERR:   state_next = ST_MUL_P;
      ST_MUL_P: state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_ACC;
      ST_ACC:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Loop state and gains.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= '0;
      gain_integ    <= '0;
      gain_deriv    <= '0;
      last_position <= '0;
      last_error    <= '0;
      error_sum     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAIN_PROP:  gain_prop  <= cfg_data;
          REG_GAIN_INTEG: gain_integ <= cfg_data;
          REG_GAIN_DERIV: gain_deriv <= cfg_data;
          default: ;
        endcase
      end
      if (s_fire) begin
        last_position <= s_tdata[POS_W-1:0];
      end
      if (state == ST_ERR) begin
        last_error <= err_c;
        error_sum  <= ESUM_W'(sum_clamped);
      end
    end
  end

  // Working registers of the sample in progress.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      delta  <= s_tdata[POS_W-1:0] - last_position;
      dt     <= s_tdata[POS_W+DT_W-1:POS_W];
      target <= s_tdata[POS_W+DT_W+SPEED_W-1:POS_W+DT_W];
    end
    unique case (state)
      ST_PREP: begin
        neg      <= num[NUM_W-1];
        spd_zero <= (dt == '0);
        spd_sat  <= (mag_hi >= HI_W'(dt));
        rem      <= (DT_W + 1)'(mag_hi);
        dq       <= mag[DIV_STEPS-1:0];
        cnt      <= '0;
      end
      ST_DIV: begin
        rem <= trial_ge ? (trial - {1'b0, dt}) : trial;
        dq  <= {dq[DIV_STEPS-2:0], trial_ge};
        cnt <= cnt + CNT_W'(1);
      end
      ST_ERR: begin
        speed <= speed_c;
        deriv <= deriv_c;
      end
      ST_MUL_I: acc <= ACC_W'(prod);
      ST_MUL_D: acc <= acc_sum;
      ST_ACC:   acc <= acc_sum;
      ST_CLAMP: acc <= acc_clamped;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_speed <= speed;
      out_ctrl  <= acc[CTRL_W-1:0];
      out_fwd   <= fwd_c;
      out_rev   <= rev_c;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input ready while a sample is in progress");

  a_integral_bounded: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(error_sum) <= ISUM_MAX) && (SUM_W'(error_sum) >= ISUM_MIN))
    else $error("integral outside its clamp");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < CNT_W'(DIV_STEPS)))
    else $error("divider step count overran");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_fwd == '0) || (out_rev == '0)))
    else $error("forward and reverse duty both nonzero");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_free) |=> (out_valid && (state == ST_IDLE)))
    else $error("finished sample not loaded into the output register");

endmodule

/* test/tb_motor_speed_pid_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID drive testbench
// Drives encoder samples and gain writes into the speed-loop PID, predicts
// every result request in step with the block and compares each field.
// ----------------------------------------------------------------------------
// The testbench keeps its own copy of the controller state (previous encoder
// count, previous error, clamped integral) and of the three gains. It works
// out the expected result when a sample request is accepted. A checker
// compares every accepted result request with the oldest expected result.
// Directed tests cover the reset gains, the dead zone and the output clamp,
// the speed extremes, encoder wrap, zero elapsed time, a zero target and the
// gain extremes. Randomised phases then track plausible motion with fresh
// gains per phase, mixed with noise. The sender idles in bursts and the
// receiver stalls on a pattern of its own, both chosen per phase.
// ----------------------------------------------------------------------------
module tb_motor_speed_pid_drive;
  import mspd_pkg::*;

  localparam int INTEG_LIMIT = 2000;
  localparam longint SPEED_LIM = 64'sd8388607;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 117;
  // Index 3 decodes to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {TX_STEADY, TX_BURSTY} tx_mode_t;
  typedef enum int {RX_ALWAYS, RX_CHOPPY, RX_LONG} rx_mode_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic signed [CTRL_W-1:0]  ctrl;
    logic [PWM_W-1:0]          fwd;
    logic [PWM_W-1:0]          rev;
  } drive_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [71:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [71:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  // Predicted controller state and gains, all zero after reset.
  longint       gain_p = 0;
  longint       gain_i = 0;
  longint       gain_d = 0;
  longint       prev_err = 0;
  longint       integ_sum = 0;
  logic [31:0]  prev_pos = '0;

  drive_result_t pending_results[$];
  int            mismatch_count = 0;

  tx_mode_t tx_mode = TX_STEADY;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       burst_left = 0;
  int       rx_left = 0;

  always #2 clk = ~clk;

  motor_speed_pid_drive #(
    .INTEGRAL_LIMIT(INTEG_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic longint clip_speed(longint v);
    if (v > SPEED_LIM) return SPEED_LIM;
    if (v < -SPEED_LIM) return -SPEED_LIM;
    return v;
  endfunction

  // Works out the result of one sample and advances the predicted state.
  function automatic drive_result_t predict_drive(logic [POS_W-1:0] pos,
                                                  logic [DT_W-1:0] dt,
                                                  logic signed [SPEED_W-1:0] target);
    drive_result_t res;
    logic [31:0]   diff;
    longint        delta, speed, err, deriv, acc, mag, tgt;
    diff = pos - prev_pos;
    delta = longint'($signed(diff));
    prev_pos = pos;
    speed = 0;
    // Division of signed integers truncates toward zero, as the block must.
    if (dt != 0) speed = clip_speed((delta * MS_PER_S) / longint'(dt));
    tgt = longint'(target);
    if (tgt == 0) begin
      err = 0;
      integ_sum = 0;
    end else begin
      err = tgt - speed;
      integ_sum = integ_sum + err;
    end
    if (integ_sum > INTEG_LIMIT) integ_sum = INTEG_LIMIT;
    if (integ_sum < -INTEG_LIMIT) integ_sum = -INTEG_LIMIT;
    deriv = err - prev_err;
    prev_err = err;
    acc = gain_p * err + gain_i * integ_sum + gain_d * deriv;
    if (acc > OUT_LIM_Q16) acc = OUT_LIM_Q16;
    if (acc < -OUT_LIM_Q16) acc = -OUT_LIM_Q16;
    res.speed = speed[SPEED_W-1:0];
    res.ctrl = acc[CTRL_W-1:0];
    res.fwd = '0;
    res.rev = '0;
    // Anything within plus or minus one point zero brakes.
    if (acc > ONE_Q16) begin
      mag = acc >>> FRAC_BITS;
      res.fwd = (mag > DUTY_MAX) ? PWM_W'(DUTY_MAX) : mag[PWM_W-1:0];
    end else if (acc < -ONE_Q16) begin
      mag = (-acc) >>> FRAC_BITS;
      res.rev = (mag > DUTY_MAX) ? PWM_W'(DUTY_MAX) : mag[PWM_W-1:0];
    end
    return res;
  endfunction

  // Writes one gain register; only called while the block is idle.
  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_PROP: gain_p = longint'($signed(value));
      REG_GAIN_INTEG: gain_i = longint'($signed(value));
      REG_GAIN_DERIV: gain_d = longint'($signed(value));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one sample request. In bursty mode a random gap may precede a new
  // burst; valid stays high between requests of the same burst.
  task automatic send_sample(logic [POS_W-1:0] pos, logic [DT_W-1:0] dt,
                             logic signed [SPEED_W-1:0] target);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_mode == TX_BURSTY) begin
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      end
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {target, dt, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_drive(pos, dt, target));
  endtask

  // Lowers valid and waits until every expected result has been taken, which
  // leaves the block idle since each sample yields exactly one result.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] random_gain();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return GAIN_W'(int'($urandom_range(0, 1048576)) - 524288);
    if (sel < 90) return GAIN_W'(int'($urandom_range(0, 8192)) - 4096);
    return GAIN_W'($urandom);
  endfunction

  // Mostly plausible motion with a target near the resulting speed; the rest
  // is noise: arbitrary counts, zero or huge elapsed times, any target.
  task automatic send_random_sample();
    logic [POS_W-1:0]          pos;
    logic [DT_W-1:0]           dt;
    logic signed [SPEED_W-1:0] tgt;
    logic [31:0]               diff;
    int unsigned               sel;
    longint                    est;
    sel = $urandom_range(0, 99);
    if (sel < 75) pos = prev_pos + 32'(int'($urandom_range(0, 4000)) - 2000);
    else if (sel < 88) pos = prev_pos + 32'(int'($urandom_range(0, 20000000)) - 10000000);
    else pos = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 78) dt = DT_W'($urandom_range(1, 50));
    else if (sel < 88) dt = '0;
    else if (sel < 96) dt = DT_W'($urandom_range(0, 65535));
    else dt = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
    diff = pos - prev_pos;
    est = 0;
    if (dt != 0) est = clip_speed((longint'($signed(diff)) * MS_PER_S) / longint'(dt));
    sel = $urandom_range(0, 99);
    if (sel < 60) tgt = SPEED_W'(clip_speed(est + int'($urandom_range(0, 600)) - 300));
    else if (sel < 72) tgt = '0;
    else tgt = SPEED_W'(int'($urandom_range(0, 16777214)) - 8388607);
    send_sample(pos, dt, tgt);
  endtask

  // With the reset gains every controller output must be zero.
  task automatic test_reset_state();
    tx_mode = TX_STEADY;
    rx_mode = RX_ALWAYS;
    send_sample(32'd0, 16'd0, 24'sd0);
    send_sample(32'd1234, 16'd10, 24'sd5000);
    drain_results();
  endtask

  // Unity proportional gain with zero elapsed time makes the output equal to
  // the target, so the dead zone edges and the output clamp are hit exactly.
  task automatic test_dead_zone();
    tx_mode = TX_BURSTY;
    rx_mode = RX_CHOPPY;
    write_gain(REG_GAIN_PROP, GAIN_W'(ONE_Q16));
    write_gain(REG_GAIN_INTEG, '0);
    write_gain(REG_GAIN_DERIV, '0);
    send_sample(prev_pos, 16'd0, 24'sd1);
    send_sample(prev_pos, 16'd0, 24'sd2);
    send_sample(prev_pos, 16'd0, -24'sd1);
    send_sample(prev_pos, 16'd0, -24'sd2);
    send_sample(prev_pos, 16'd0, 24'sd255);
    send_sample(prev_pos, 16'd0, 24'sd256);
    send_sample(prev_pos, 16'd0, -24'sd300);
    send_sample(prev_pos, 16'd0, 24'sd8388607);
    send_sample(prev_pos, 16'd0, -24'sd8388607);
    send_sample(prev_pos, 16'd0, 24'sd0);
    drain_results();
  endtask

  // Saturating speeds in both directions, a wrap of the encoder count, the
  // longest elapsed time and truncation of a negative quotient.
  task automatic test_speed_extremes();
    tx_mode = TX_STEADY;
    rx_mode = RX_LONG;
    write_gain(REG_GAIN_PROP, 32'h0000_8000);
    write_gain(REG_GAIN_INTEG, 32'h0000_0100);
    write_gain(REG_GAIN_DERIV, 32'hFFFF_0000);
    send_sample(32'h0000_0000, 16'd0, -24'sd1);
    send_sample(32'h7FFF_FFFF, 16'd1, 24'sd8388607);
    send_sample(32'h8000_0000, 16'hFFFF, -24'sd8388607);
    send_sample(32'h0000_0000, 16'd1, 24'sd12345);
    send_sample(32'hFFFF_FFF0, 16'd3, -24'sd5000);
    drain_results();
  endtask

  // A zero target clears the error and the integral; the derivative then
  // sees the negative of the previous error.
  task automatic test_zero_target();
    tx_mode = TX_BURSTY;
    rx_mode = RX_ALWAYS;
    write_gain(REG_GAIN_PROP, '0);
    write_gain(REG_GAIN_INTEG, GAIN_W'(ONE_Q16));
    write_gain(REG_GAIN_DERIV, GAIN_W'(ONE_Q16));
    send_sample(prev_pos + 32'd100, 16'd10, 24'sd500);
    send_sample(prev_pos + 32'd7, 16'd10, 24'sd0);
    send_sample(prev_pos, 16'd5, 24'sd0);
    send_sample(prev_pos, 16'd0, 24'sd300);
    drain_results();
  endtask

  // The largest and smallest gains, plus a write to the unused index.
  task automatic test_gain_extremes();
    tx_mode = TX_STEADY;
    rx_mode = RX_CHOPPY;
    write_gain(REG_GAIN_PROP, 32'h7FFF_FFFF);
    write_gain(REG_GAIN_INTEG, 32'h8000_0000);
    write_gain(REG_GAIN_DERIV, 32'h8000_0000);
    write_gain(REG_SPARE, $urandom);
    send_sample(prev_pos + 32'd50, 16'd20, 24'sd8388607);
    send_sample(prev_pos - 32'd50, 16'd20, -24'sd8388607);
    drain_results();
    write_gain(REG_GAIN_PROP, 32'h8000_0000);
    write_gain(REG_GAIN_INTEG, 32'h7FFF_FFFF);
    write_gain(REG_GAIN_DERIV, 32'h7FFF_FFFF);
    send_sample(prev_pos + 32'd1, 16'd1000, 24'sd1);
    send_sample(prev_pos, 16'd0, -24'sd1);
    drain_results();
  endtask

  // Random phases, each with fresh gains and its own idling on both sides.
  // The first phase runs without any idling.
  task automatic test_random_tracking();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 3)
        0: rx_mode = (ph == 0) ? RX_ALWAYS : RX_LONG;
        1: rx_mode = RX_CHOPPY;
        default: rx_mode = RX_LONG;
      endcase
      tx_mode = (ph == 0 || ph == 3) ? TX_STEADY : TX_BURSTY;
      write_gain(REG_GAIN_PROP, random_gain());
      write_gain(REG_GAIN_INTEG, random_gain());
      write_gain(REG_GAIN_DERIV, random_gain());
      for (int n = 0; n < PHASE_SAMPLES; n++) send_random_sample();
      drain_results();
    end
  endtask

  // Receiver readiness: always ready, short random stalls, or alternating
  // ready runs and long stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      case (rx_mode)
        RX_ALWAYS: begin
          m_tready <= 1'b1;
          rx_left <= 8;
        end
        RX_CHOPPY: begin
          m_tready <= ($urandom_range(0, 3) != 0);
          rx_left <= $urandom_range(0, 3);
        end
        default: begin
          m_tready <= ~m_tready;
          rx_left <= m_tready ? $urandom_range(5, 60) : $urandom_range(0, 10);
        end
      endcase
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Each accepted result request is compared field by field with the oldest
  // expected result.
  always @(posedge clk) begin : result_check
    drive_result_t got;
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.speed = m_tdata[23:0];
      got.ctrl = m_tdata[48:24];
      got.fwd = m_tdata[56:49];
      got.rev = m_tdata[64:57];
      if (pending_results.size() == 0) begin
        $error("result request with no sample pending: m_tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.speed !== want.speed) begin
          $error("measured_speed: expected %0d, actual %0d", want.speed, got.speed);
          mismatch_count++;
        end
        if (got.ctrl !== want.ctrl) begin
          $error("control_value: expected %0d, actual %0d", want.ctrl, got.ctrl);
          mismatch_count++;
        end
        if (got.fwd !== want.fwd) begin
          $error("forward_pwm: expected %0d, actual %0d", want.fwd, got.fwd);
          mismatch_count++;
        end
        if (got.rev !== want.rev) begin
          $error("reverse_pwm: expected %0d, actual %0d", want.rev, got.rev);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_dead_zone();
    test_speed_extremes();
    test_zero_target();
    test_gain_extremes();
    test_random_tracking();
    // Give a stray extra result time to show up after the last one.
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
